// ===== rtl/dsf_pkg.sv =====
// Shared types and constants for the depth sort block.
package dsf_pkg;

    // Field widths of one face.
    localparam int DEPTH_W       = 32;
    localparam int TAG_W         = 16;
    localparam int MAX_FACES_DEF = 64;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    // Controller states.
    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } dsf_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;
        logic drop;
        logic pop;
    } dsf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic one_left;
    } dsf_stat_t;

endpackage

// ===== rtl/dsf_datapath.sv =====
// Insertion row that keeps stored faces sorted by depth and shifts them out in order.
module dsf_datapath #(
    parameter int MAX_FACES = dsf_pkg::MAX_FACES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dsf_pkg::dsf_cmd_t                   cmd,
    output dsf_pkg::dsf_stat_t                  stat,
    input  logic signed [dsf_pkg::DEPTH_W-1:0]  in_key,
    input  logic [dsf_pkg::TAG_W-1:0]           in_tag,
    input  logic                                in_cull,
    output logic signed [dsf_pkg::DEPTH_W-1:0]  out_key,
    output logic [dsf_pkg::TAG_W-1:0]           out_tag,
    output logic                                out_cull,
    output logic                                out_ovf
);
    import dsf_pkg::*;

    localparam int CNT_W = $clog2(MAX_FACES + 1);

    logic signed [DEPTH_W-1:0] key_reg [MAX_FACES];
    logic [TAG_W-1:0]          tag_reg [MAX_FACES];
    logic                      cull_reg [MAX_FACES];
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      ovf_reg, ovf_next;

    // Per cell: its stored face is valid and at least as far as the new one.
    logic [MAX_FACES-1:0] ge;
    // Neighbor views used by the insert and pop moves.
    logic [MAX_FACES-1:0]      prev_ge;
    logic signed [DEPTH_W-1:0] prv_key [MAX_FACES];
    logic [TAG_W-1:0]          prv_tag [MAX_FACES];
    logic                      prv_cull [MAX_FACES];
    logic signed [DEPTH_W-1:0] nxt_key [MAX_FACES];
    logic [TAG_W-1:0]          nxt_tag [MAX_FACES];
    logic                      nxt_cull [MAX_FACES];

    genvar i;
    generate
        for (i = 0; i < MAX_FACES; i++) begin : g_cell
            assign ge[i] = (CNT_W'(i) < cnt_reg) && (key_reg[i] >= in_key);

            if (i == 0) begin : g_first
                assign prev_ge[i]  = 1'b1;
                assign prv_key[i]  = in_key;
                assign prv_tag[i]  = in_tag;
                assign prv_cull[i] = in_cull;
            end else begin : g_mid
                assign prev_ge[i]  = ge[i-1];
                assign prv_key[i]  = key_reg[i-1];
                assign prv_tag[i]  = tag_reg[i-1];
                assign prv_cull[i] = cull_reg[i-1];
            end

            if (i == MAX_FACES - 1) begin : g_tail
                assign nxt_key[i]  = key_reg[i];
                assign nxt_tag[i]  = tag_reg[i];
                assign nxt_cull[i] = cull_reg[i];
            end else begin : g_body
                assign nxt_key[i]  = key_reg[i+1];
                assign nxt_tag[i]  = tag_reg[i+1];
                assign nxt_cull[i] = cull_reg[i+1];
            end

            // A cell behind the insertion point takes the new face or its left
            // neighbor; popping moves every face one cell toward the head.
            always_ff @(posedge aclk) begin
                if (cmd.insert && !ge[i]) begin
                    if (prev_ge[i]) begin
                        key_reg[i]  <= in_key;
                        tag_reg[i]  <= in_tag;
                        cull_reg[i] <= in_cull;
                    end else begin
                        key_reg[i]  <= prv_key[i];
                        tag_reg[i]  <= prv_tag[i];
                        cull_reg[i] <= prv_cull[i];
                    end
                end else if (cmd.pop) begin
                    key_reg[i]  <= nxt_key[i];
                    tag_reg[i]  <= nxt_tag[i];
                    cull_reg[i] <= nxt_cull[i];
                end
            end
        end
    endgenerate

    // Face count and overflow mark for the current frame.
    always_comb begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (cmd.insert) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (cmd.drop) begin
            ovf_next = 1'b1;
        end else if (cmd.pop && stat.one_left) begin
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

    assign stat.full     = (cnt_reg == CNT_W'(MAX_FACES));
    assign stat.one_left = (cnt_reg == CNT_W'(1));

    // The head cell is the farthest stored face.
    assign out_key  = key_reg[0];
    assign out_tag  = tag_reg[0];
    assign out_cull = cull_reg[0];
    assign out_ovf  = ovf_reg;

`ifndef SYNTHESIS
    // The count never passes the capacity of the row.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_FACES))
        else $error("face count beyond capacity");

    // Popping the final face empties the row and clears the overflow mark.
    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pop && stat.one_left && !cmd.insert && !cmd.drop)
        |=> (cnt_reg == '0) && !ovf_reg)
        else $error("frame did not end cleanly");

    // The two head cells stay in descending depth order.
    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg >= CNT_W'(2)) |-> (key_reg[0] >= key_reg[1]))
        else $error("head cells out of order");

    // No face is inserted into a full row.
    a_no_insert_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |-> !stat.full)
        else $error("insert into full row");
`endif

endmodule

// ===== rtl/dsf_ctrl.sv =====
// Controller that sequences face loading and sorted output.
module dsf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               m_tlast,
    input  dsf_pkg::dsf_stat_t stat,
    output dsf_pkg::dsf_cmd_t  cmd
);
    import dsf_pkg::*;

    dsf_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Load faces until the last item, then hand out the sorted run.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        m_tlast    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.insert = !stat.full;
                    cmd.drop   = stat.full;
                    if (s_tlast) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                m_tlast  = stat.one_left;
                if (m_tready) begin
                    cmd.pop = 1'b1;
                    if (stat.one_left) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== rtl/depth_sort_faces_top.sv =====
// A face is taken and put into depth order as it arrives.
// The first sorted item is offered in the cycle after the last face is taken.
// Throughput: one face per cycle while loading and one item per cycle while
// emitting, as long as m_tready is high.
// Reset (synchronous, active low) empties the frame and clears the overflow
// mark; stored face data is not cleared and needs no clearing pass.
module depth_sort_faces_top #(
    parameter int MAX_FACES = dsf_pkg::MAX_FACES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dsf_pkg::S_TDATA_W-1:0]   s_tdata,  // depth_key[31:0], face_tag[47:32]
    input  logic                            s_tuser,  // cull_flag
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dsf_pkg::M_TDATA_W-1:0]   m_tdata,  // out_tag[15:0], out_depth[47:16]
    output logic [dsf_pkg::M_TUSER_W-1:0]   m_tuser,  // out_cull[0], overflow[1]
    output logic                            m_tlast
);
    import dsf_pkg::*;

    dsf_cmd_t                  cmd;
    dsf_stat_t                 stat;
    logic signed [DEPTH_W-1:0] out_key;
    logic [TAG_W-1:0]          out_tag;
    logic                      out_cull;
    logic                      out_ovf;

    dsf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .stat     (stat),
        .cmd      (cmd)
    );

    dsf_datapath #(
        .MAX_FACES (MAX_FACES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_key   ($signed(s_tdata[DEPTH_W-1:0])),
        .in_tag   (s_tdata[DEPTH_W +: TAG_W]),
        .in_cull  (s_tuser),
        .out_key  (out_key),
        .out_tag  (out_tag),
        .out_cull (out_cull),
        .out_ovf  (out_ovf)
    );

    // Pack the head face onto the result stream.
    assign m_tdata = {out_key, out_tag};
    assign m_tuser = {out_ovf, out_cull};

endmodule
